// ----- design/ssrr_pkg.sv -----
package ssrr_pkg;

  localparam int MAX_DIGITS    = 4;
  localparam int SEGMENT_COUNT = 7;
  localparam int NUM_LIMIT     = 10000;

  localparam int NUM_W   = 14;
  localparam int CFG_W   = 10;
  localparam int POS_W   = 2;
  localparam int SEG_W   = 3;
  localparam int COORD_W = 13;
  localparam int SIZE_W  = 9;

  // constant reciprocals: x/3 = (x*171)>>9 for 8-bit x, x/10 = (x*6554)>>16 below 10000
  localparam int DIV3_RECIP   = 171;
  localparam int DIV3_SHIFT   = 9;
  localparam int DIV10_RECIP  = 6554;
  localparam int DIV10_SHIFT  = 16;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ORIGIN_Y   = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_X   = 3'd1;
  localparam cfg_idx_t CFG_SEG_WIDTH  = 3'd2;
  localparam cfg_idx_t CFG_DIGIT_CNT  = 3'd3;
  localparam cfg_idx_t CFG_LINE_WIDTH = 3'd4;
  localparam cfg_idx_t CFG_KEEP_LW    = 3'd5;
  localparam cfg_idx_t CFG_GAP        = 3'd6;
  localparam cfg_idx_t CFG_KEEP_GAP   = 3'd7;

  typedef logic [SEG_W-1:0] seg_t;
  localparam seg_t SEG_TOP    = 3'd0;
  localparam seg_t SEG_UL     = 3'd1;
  localparam seg_t SEG_UR     = 3'd2;
  localparam seg_t SEG_MID    = 3'd3;
  localparam seg_t SEG_LL     = 3'd4;
  localparam seg_t SEG_LR     = 3'd5;
  localparam seg_t SEG_BOTTOM = 3'd6;

  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_DIV3  = 3'd1;
  localparam step_t STEP_GEOM  = 3'd2;
  localparam step_t STEP_PITCH = 3'd3;
  localparam step_t STEP_DIGQ  = 3'd4;
  localparam step_t STEP_DIGR  = 3'd5;
  localparam step_t STEP_EMIT  = 3'd6;

  typedef enum logic [1:0] {
    COND_NEXT  = 2'd0,
    COND_START = 2'd1,
    COND_DIGIT = 2'd2,
    COND_EMIT  = 2'd3
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    logic  ld_div3;
    logic  ld_geom;
    logic  ld_pitch;
    logic  dig_q;
    logic  dig_r;
    logic  emit;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic dig_more;
    logic emit_stall;
    logic emit_final;
  } seq_sts_t;

  function automatic ucode_t ucode_rom(input step_t st);
    ucode_t w;
    w        = '0;
    w.cond   = COND_NEXT;
    w.target = STEP_IDLE;
    case (st)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_START;
      end
      STEP_DIV3:  w.ld_div3  = 1'b1;
      STEP_GEOM:  w.ld_geom  = 1'b1;
      STEP_PITCH: w.ld_pitch = 1'b1;
      STEP_DIGQ:  w.dig_q    = 1'b1;
      STEP_DIGR: begin
        w.dig_r  = 1'b1;
        w.cond   = COND_DIGIT;
        w.target = STEP_DIGQ;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_EMIT;
        w.target = STEP_IDLE;
      end
      default: w.target = STEP_IDLE;
    endcase
    return w;
  endfunction

  // bit s set: segment s is dark for that digit
  function automatic logic [SEGMENT_COUNT-1:0] glyph_off(input logic [3:0] d);
    logic [SEGMENT_COUNT-1:0] g;
    case (d)
      4'd0:    g = 7'h08;
      4'd1:    g = 7'h5B;
      4'd2:    g = 7'h22;
      4'd3:    g = 7'h12;
      4'd4:    g = 7'h51;
      4'd5:    g = 7'h14;
      4'd6:    g = 7'h05;
      4'd7:    g = 7'h5A;
      4'd8:    g = 7'h00;
      4'd9:    g = 7'h50;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

// ----- design/ssrr_in_if.sv -----
interface ssrr_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssrr_pkg::NUM_W-1:0]    number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// ----- design/ssrr_out_if.sv -----
interface ssrr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ssrr_pkg::COORD_W-1:0] rect_y;
  logic signed [ssrr_pkg::COORD_W-1:0] rect_x;
  logic [ssrr_pkg::SIZE_W-1:0]         rect_w;
  logic [ssrr_pkg::SIZE_W-1:0]         rect_h;
  logic                                erase;
  logic [ssrr_pkg::POS_W-1:0]          digit_pos;
  logic [ssrr_pkg::SEG_W-1:0]          segment_index;
  logic                                last;

  modport source (output valid, output rect_y, output rect_x, output rect_w, output rect_h,
                  output erase, output digit_pos, output segment_index, output last,
                  input ready);
  modport sink   (input valid, input rect_y, input rect_x, input rect_w, input rect_h,
                  input erase, input digit_pos, input segment_index, input last,
                  output ready);
endinterface

// ----- design/seven_segment_rect_renderer.sv -----
// Draws a number of up to four decimal digits as seven-segment fill rectangles: one output
// beat per segment, 7 x min(digit_count, 4) beats in digit-then-segment order, the last
// one flagged. A number of 10000 or more, or a digit count of zero, is taken and gives no
// beats. Otherwise a small microcoded step sequencer runs the item: an accept step, three
// geometry set-up steps (stroke, gap and segment lengths through a constant-reciprocal
// multiply), a quotient and a remainder step per digit through the shared divide-by-ten
// unit, then one beat per cycle while the output is not stalled. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module seven_segment_rect_renderer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [ssrr_pkg::CFG_W-1:0]  cfg_data,
  ssrr_in_if.sink                     in_ch,
  ssrr_out_if.source                  out_ch
);

  // configuration
  logic [9:0] origin_y_r, origin_x_r;
  logic [7:0] seg_width_r, gap_cfg_r;
  logic [2:0] digit_count_r;
  logic [5:0] line_width_r;
  logic       keep_lw_r, keep_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_y_r    <= 10'd8;
      origin_x_r    <= 10'd8;
      seg_width_r   <= 8'd12;
      digit_count_r <= 3'd4;
      line_width_r  <= 6'd2;
      keep_lw_r     <= 1'b0;
      gap_cfg_r     <= 8'd6;
      keep_gap_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssrr_pkg::CFG_ORIGIN_Y:   origin_y_r    <= cfg_data;
        ssrr_pkg::CFG_ORIGIN_X:   origin_x_r    <= cfg_data;
        ssrr_pkg::CFG_SEG_WIDTH:  seg_width_r   <= cfg_data[7:0];
        ssrr_pkg::CFG_DIGIT_CNT:  digit_count_r <= cfg_data[2:0];
        ssrr_pkg::CFG_LINE_WIDTH: line_width_r  <= cfg_data[5:0];
        ssrr_pkg::CFG_KEEP_LW:    keep_lw_r     <= cfg_data[0];
        ssrr_pkg::CFG_GAP:        gap_cfg_r     <= cfg_data[7:0];
        ssrr_pkg::CFG_KEEP_GAP:   keep_gap_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  ssrr_pkg::ucode_t   ctrl;
  ssrr_pkg::seq_sts_t sts;

  ssrr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctrl  (ctrl)
  );

  // datapath registers
  logic [ssrr_pkg::NUM_W-1:0] num_r;
  logic [9:0]                 q_r;
  logic [3:0]                 digs_r [ssrr_pkg::MAX_DIGITS];
  logic [ssrr_pkg::POS_W-1:0] cnt_m1_r, dig_i_r, p_r;
  logic [ssrr_pkg::SEG_W-1:0] s_r;
  logic [6:0]                 sw3_r;
  logic [5:0]                 lw_r;
  logic [7:0]                 gp_r;
  logic [8:0]                 sh_r, swl_r, swl2_r, shlw_r;
  logic [9:0]                 pitch_r;
  logic [10:0]                x1lw_r, x2_r, x3_r;
  logic [11:0]                dy1_r;

  logic                       accept, reject, out_free, emit_fire, emit_final;
  logic [2:0]                 cnt_clamp;
  logic [15:0]                sw_prod;
  logic [26:0]                num_prod;
  logic [ssrr_pkg::NUM_W-1:0] q_ext, rem;
  logic [5:0]                 sw6, lw_pick;
  logic [ssrr_pkg::SEGMENT_COUNT-1:0] glyph;
  logic                       del;
  logic [10:0]                x1;
  logic [12:0]                y_off, ry, rx;
  logic [8:0]                 rw, rh;

  assign in_ch.ready = ctrl.in_rdy;
  assign accept      = in_ch.valid && ctrl.in_rdy;
  assign reject      = (in_ch.number >= 14'(ssrr_pkg::NUM_LIMIT)) || (digit_count_r == 3'd0);
  assign cnt_clamp   = (digit_count_r > 3'(ssrr_pkg::MAX_DIGITS)) ?
                       3'(ssrr_pkg::MAX_DIGITS) : digit_count_r;

  assign sw_prod  = 16'(seg_width_r) * 16'(ssrr_pkg::DIV3_RECIP);
  assign num_prod = 27'(num_r) * 27'(ssrr_pkg::DIV10_RECIP);
  assign q_ext    = 14'(q_r);
  assign rem      = num_r - (q_ext << 3) - (q_ext << 1);
  assign sw6      = 6'(sw3_r >> 1);
  assign lw_pick  = keep_lw_r ? line_width_r : sw6;

  assign out_free   = !out_ch.valid || out_ch.ready;
  assign emit_fire  = ctrl.emit && out_free;
  assign emit_final = (p_r == cnt_m1_r) && (s_r == ssrr_pkg::SEG_BOTTOM);

  assign sts.start      = accept && !reject;
  assign sts.dig_more   = dig_i_r != '0;
  assign sts.emit_stall = !out_free;
  assign sts.emit_final = emit_final;

  always_ff @(posedge clk) begin
    if (accept) begin
      num_r    <= in_ch.number;
      cnt_m1_r <= 2'(cnt_clamp - 3'd1);
      dig_i_r  <= 2'(cnt_clamp - 3'd1);
    end
    if (ctrl.ld_div3) sw3_r <= sw_prod[ssrr_pkg::DIV3_SHIFT +: 7];
    if (ctrl.ld_geom) begin
      lw_r <= (lw_pick == 6'd0) ? 6'd1 : lw_pick;
      gp_r <= keep_gap_r ? gap_cfg_r : {1'b0, seg_width_r[7:1]};
      sh_r <= 9'(seg_width_r) + 9'(sw3_r);
    end
    if (ctrl.ld_pitch) begin
      pitch_r <= 10'(seg_width_r) + 10'(lw_r) + 10'(gp_r);
      swl_r   <= 9'(seg_width_r) + 9'(lw_r);
      swl2_r  <= 9'(seg_width_r) + 9'({lw_r, 1'b0});
      shlw_r  <= sh_r + 9'(lw_r);
      x1lw_r  <= 11'(origin_x_r) + 11'(lw_r);
      x2_r    <= 11'(origin_x_r) + 11'(sh_r);
      x3_r    <= 11'(origin_x_r) + 11'({sh_r, 1'b0});
    end
    if (ctrl.dig_q) q_r <= num_prod[ssrr_pkg::DIV10_SHIFT +: 10];
    if (ctrl.dig_r) begin
      digs_r[dig_i_r] <= rem[3:0];
      num_r           <= q_ext;
      if (dig_i_r != '0) dig_i_r <= dig_i_r - 2'd1;
    end
  end

  // beat position and digit row start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
      s_r <= ssrr_pkg::SEG_TOP;
    end else if (accept) begin
      p_r <= '0;
      s_r <= ssrr_pkg::SEG_TOP;
    end else if (emit_fire) begin
      if (s_r == ssrr_pkg::SEG_BOTTOM) begin
        s_r <= ssrr_pkg::SEG_TOP;
        p_r <= p_r + 2'd1;
      end else begin
        s_r <= s_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_pitch) dy1_r <= 12'(origin_y_r);
    else if (emit_fire && (s_r == ssrr_pkg::SEG_BOTTOM)) dy1_r <= dy1_r + 12'(pitch_r);
  end

  // rectangle for the current segment
  assign glyph = ssrr_pkg::glyph_off(digs_r[p_r]);
  assign del   = glyph[s_r];
  assign x1    = 11'(origin_x_r);

  always_comb begin
    case (s_r)
      ssrr_pkg::SEG_TOP: begin
        y_off = 13'd0 - 13'(lw_r); rx = 13'(x1);   rw = swl2_r;    rh = 9'(lw_r);
      end
      ssrr_pkg::SEG_UL: begin
        y_off = 13'd0 - 13'(lw_r); rx = 13'(del ? x1lw_r : x1); rw = 9'(lw_r); rh = sh_r;
      end
      ssrr_pkg::SEG_UR: begin
        y_off = 13'(seg_width_r);  rx = 13'(del ? x1lw_r : x1); rw = 9'(lw_r); rh = sh_r;
      end
      ssrr_pkg::SEG_MID: begin
        y_off = 13'd0;             rx = 13'(x2_r); rw = swl_r;     rh = 9'(lw_r);
      end
      ssrr_pkg::SEG_LL: begin
        y_off = 13'd0 - 13'(lw_r); rx = 13'(x2_r); rw = 9'(lw_r);  rh = shlw_r;
      end
      ssrr_pkg::SEG_LR: begin
        y_off = 13'(seg_width_r);  rx = 13'(x2_r); rw = 9'(lw_r);  rh = shlw_r;
      end
      default: begin
        y_off = 13'd0 - 13'(lw_r); rx = 13'(x3_r); rw = swl_r;     rh = 9'(lw_r);
      end
    endcase
  end

  assign ry = 13'(dy1_r) + y_off;

  // output register
  logic       out_valid_r, out_erase_r, out_last_r;
  logic [12:0] out_y_r, out_x_r;
  logic [8:0]  out_w_r, out_h_r;
  logic [ssrr_pkg::POS_W-1:0] out_pos_r;
  logic [ssrr_pkg::SEG_W-1:0] out_seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit_fire) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_y_r     <= ry;
      out_x_r     <= rx;
      out_w_r     <= rw;
      out_h_r     <= rh;
      out_erase_r <= del;
      out_pos_r   <= p_r;
      out_seg_r   <= s_r;
      out_last_r  <= emit_final;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rect_y        = $signed(out_y_r);
  assign out_ch.rect_x        = $signed(out_x_r);
  assign out_ch.rect_w        = out_w_r;
  assign out_ch.rect_h        = out_h_r;
  assign out_ch.erase         = out_erase_r;
  assign out_ch.digit_pos     = out_pos_r;
  assign out_ch.segment_index = out_seg_r;
  assign out_ch.last          = out_last_r;

  // the final beat hands control back to the accept step
  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && emit_final |=> ctrl.in_rdy)
    else $error("sequencer did not return to accept after final beat");

  // digits produced by the divider are always decimal
  a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> (digs_r[p_r] <= 4'd9))
    else $error("stored digit out of range");

  // the flagged beat closes a digit
  a_last_on_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> (out_seg_r == ssrr_pkg::SEG_BOTTOM))
    else $error("last beat is not a bottom segment");

  // no beat is produced while a new number can be taken
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.in_rdy |=> !$rose(out_valid_r) || $past(emit_fire))
    else $error("beat raised without an emit step");

endmodule

// ----- design/ssrr_seq.sv -----
module ssrr_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  ssrr_pkg::seq_sts_t sts,
  output ssrr_pkg::ucode_t   ctrl
);

  ssrr_pkg::step_t step_r;
  ssrr_pkg::step_t step_nxt;
  ssrr_pkg::step_t step_inc;

  assign ctrl     = ssrr_pkg::ucode_rom(step_r);
  assign step_inc = step_r + 3'd1;

  always_comb begin
    case (ctrl.cond)
      ssrr_pkg::COND_NEXT:  step_nxt = step_inc;
      ssrr_pkg::COND_START: step_nxt = sts.start ? step_inc : step_r;
      ssrr_pkg::COND_DIGIT: step_nxt = sts.dig_more ? ctrl.target : step_inc;
      ssrr_pkg::COND_EMIT: begin
        if (sts.emit_stall) step_nxt = step_r;
        else if (sts.emit_final) step_nxt = ctrl.target;
        else step_nxt = step_r;
      end
      default: step_nxt = ssrr_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= ssrr_pkg::STEP_IDLE;
    else step_r <= step_nxt;
  end

endmodule

// ----- bench/seven_segment_rect_renderer_tb.sv -----
`timescale 1ns / 100ps

module seven_segment_rect_renderer_tb;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_PAUSE     = 12;
  localparam int RAND_PHASES   = 6;
  localparam int RAND_PER_SET  = 32;

  // bit s set: segment s dark for that digit
  localparam logic [ssrr_pkg::SEGMENT_COUNT-1:0] DARK_SEGS [10] = '{
    7'h08, 7'h5B, 7'h22, 7'h12, 7'h51, 7'h14, 7'h05, 7'h5A, 7'h00, 7'h50
  };

  typedef logic [ssrr_pkg::CFG_W-1:0] reg_set_t [8];

  typedef struct packed {
    logic signed [ssrr_pkg::COORD_W-1:0] ry;
    logic signed [ssrr_pkg::COORD_W-1:0] rx;
    logic [ssrr_pkg::SIZE_W-1:0]         rw;
    logic [ssrr_pkg::SIZE_W-1:0]         rh;
    logic                                erase;
    logic [ssrr_pkg::POS_W-1:0]          pos;
    ssrr_pkg::seg_t                      seg;
    logic                                last;
  } rect_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  ssrr_pkg::cfg_idx_t         cfg_index;
  logic [ssrr_pkg::CFG_W-1:0] cfg_data;

  ssrr_in_if  in_ch();
  ssrr_out_if out_ch();

  seven_segment_rect_renderer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // register shadow
  logic [9:0] m_oy       = 10'd8;
  logic [9:0] m_ox       = 10'd8;
  logic [7:0] m_sw       = 8'd12;
  logic [2:0] m_digits   = 3'd4;
  logic [5:0] m_lw       = 6'd2;
  logic       m_keep_lw  = 1'b0;
  logic [7:0] m_gap      = 8'd6;
  logic       m_keep_gap = 1'b0;

  logic [ssrr_pkg::NUM_W-1:0] number_q[$];
  rect_t                      rect_expq[$];
  bit                         no_idle = 1'b0;

  int send_pause;
  int stall_left;
  int out_draw;
  int idle_cycles;
  int n_bad;
  int n_numbers;
  int n_rejected;
  int n_rects;
  int n_settings;

  rect_t got_rect;
  rect_t want_rect;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void predict_rects(input logic [ssrr_pkg::NUM_W-1:0] num);
    int n_dig, sw, stroke, spacing, sh, x1, x2, x3, dy1, dy2, v, total, k;
    int ry, rx, rw, rh;
    int digs[ssrr_pkg::MAX_DIGITS];
    logic [ssrr_pkg::SEGMENT_COUNT-1:0] dark;
    logic off;
    rect_t r;
    if (num >= ssrr_pkg::NUM_LIMIT) return;
    n_dig = (m_digits > ssrr_pkg::MAX_DIGITS) ? ssrr_pkg::MAX_DIGITS : int'(m_digits);
    if (n_dig == 0) return;
    v = num;
    for (int p = n_dig - 1; p >= 0; p--) begin
      digs[p] = v % 10;
      v = v / 10;
    end
    sw = m_sw;
    stroke = m_keep_lw ? int'(m_lw) : sw / 6;
    if (stroke < 1) stroke = 1;
    spacing = m_keep_gap ? int'(m_gap) : sw / 2;
    sh = sw + sw / 3;
    x1 = m_ox;
    x2 = x1 + sh;
    x3 = x2 + sh;
    total = n_dig * ssrr_pkg::SEGMENT_COUNT;
    k = 0;
    for (int p = 0; p < n_dig; p++) begin
      dy1 = int'(m_oy) + p * (sw + stroke) + p * spacing;
      dy2 = dy1 + sw + stroke;
      dark = DARK_SEGS[digs[p]];
      for (int s = 0; s < ssrr_pkg::SEGMENT_COUNT; s++) begin
        off = dark[s];
        case (ssrr_pkg::seg_t'(s))
          ssrr_pkg::SEG_TOP: begin
            ry = dy1 - stroke; rx = x1; rw = dy2 - dy1 + stroke; rh = stroke;
          end
          ssrr_pkg::SEG_UL: begin
            ry = dy1 - stroke; rx = off ? x1 + stroke : x1; rw = stroke; rh = x2 - x1;
          end
          ssrr_pkg::SEG_UR: begin
            ry = dy2 - stroke; rx = off ? x1 + stroke : x1; rw = stroke; rh = x2 - x1;
          end
          ssrr_pkg::SEG_MID: begin
            ry = dy1; rx = x2; rw = dy2 - dy1; rh = stroke;
          end
          ssrr_pkg::SEG_LL: begin
            ry = dy1 - stroke; rx = x2; rw = stroke; rh = x3 - x2 + stroke;
          end
          ssrr_pkg::SEG_LR: begin
            ry = dy2 - stroke; rx = x2; rw = stroke; rh = x3 - x2 + stroke;
          end
          default: begin
            ry = dy1 - stroke; rx = x3; rw = dy2 - dy1; rh = stroke;
          end
        endcase
        r.ry    = ry[ssrr_pkg::COORD_W-1:0];
        r.rx    = rx[ssrr_pkg::COORD_W-1:0];
        r.rw    = rw[ssrr_pkg::SIZE_W-1:0];
        r.rh    = rh[ssrr_pkg::SIZE_W-1:0];
        r.erase = off;
        r.pos   = p[ssrr_pkg::POS_W-1:0];
        r.seg   = ssrr_pkg::seg_t'(s);
        r.last  = (k == total - 1);
        rect_expq.push_back(r);
        k++;
      end
    end
  endfunction

  function automatic string rect_str(input rect_t r);
    return $sformatf("y=%0d x=%0d w=%0d h=%0d erase=%0b pos=%0d seg=%0d last=%0b",
                     r.ry, r.rx, r.rw, r.rh, r.erase, r.pos, r.seg, r.last);
  endfunction

  // input side: number_q feeds the channel, random pause after each beat unless no_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.number <= '0;
      send_pause   <= 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (send_pause > 0) begin
        send_pause  <= send_pause - 1;
        in_ch.valid <= 1'b0;
      end else if (number_q.size() > 0) begin
        in_ch.valid  <= 1'b1;
        in_ch.number <= number_q.pop_front();
        send_pause   <= no_idle ? 0 : $urandom_range(0, MAX_PAUSE);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output side: predict on accepted numbers, check accepted beats, random back-pressure unless no_idle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        n_numbers++;
        if (in_ch.number >= ssrr_pkg::NUM_LIMIT) n_rejected++;
        predict_rects(in_ch.number);
      end
      if (out_ch.valid && out_ch.ready) begin
        got_rect = '{out_ch.rect_y, out_ch.rect_x, out_ch.rect_w, out_ch.rect_h,
                     out_ch.erase, out_ch.digit_pos, out_ch.segment_index, out_ch.last};
        n_rects++;
        if (rect_expq.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("%0t: unexpected beat: %s", $realtime, rect_str(got_rect));
        end else begin
          want_rect = rect_expq.pop_front();
          if (got_rect.ry !== want_rect.ry || got_rect.rx !== want_rect.rx ||
              got_rect.rw !== want_rect.rw || got_rect.rh !== want_rect.rh ||
              got_rect.erase !== want_rect.erase || got_rect.pos !== want_rect.pos ||
              got_rect.seg !== want_rect.seg || got_rect.last !== want_rect.last) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: rect mismatch", $realtime);
              $display("  expected %s", rect_str(want_rect));
              $display("  actual   %s", rect_str(got_rect));
            end
          end
        end
        out_draw     = no_idle ? 0 : $urandom_range(0, MAX_PAUSE);
        stall_left   <= out_draw;
        out_ch.ready <= (out_draw == 0);
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= (stall_left == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d rects outstanding",
               $realtime, IDLE_LIMIT, rect_expq.size());
      $display("** seven_segment_rect_renderer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic load_settings(input reg_set_t vals);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= ssrr_pkg::cfg_idx_t'(i);
      cfg_data  <= vals[i];
      case (ssrr_pkg::cfg_idx_t'(i))
        ssrr_pkg::CFG_ORIGIN_Y:   m_oy       = vals[i][9:0];
        ssrr_pkg::CFG_ORIGIN_X:   m_ox       = vals[i][9:0];
        ssrr_pkg::CFG_SEG_WIDTH:  m_sw       = vals[i][7:0];
        ssrr_pkg::CFG_DIGIT_CNT:  m_digits   = vals[i][2:0];
        ssrr_pkg::CFG_LINE_WIDTH: m_lw       = vals[i][5:0];
        ssrr_pkg::CFG_KEEP_LW:    m_keep_lw  = vals[i][0];
        ssrr_pkg::CFG_GAP:        m_gap      = vals[i][7:0];
        default:                  m_keep_gap = vals[i][0];
      endcase
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // waits until every number is sent and every rect is back, then lets the block settle
  task automatic drain();
    do @(negedge clk);
    while (number_q.size() != 0 || in_ch.valid || rect_expq.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    reg_set_t                   vals;
    int                         good;
    logic [ssrr_pkg::NUM_W-1:0] num;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = ssrr_pkg::CFG_ORIGIN_Y;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.number = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes of the number, every digit glyph, rejects
    number_q = '{14'd0, 14'd16383, 14'd10000, 14'd9999, 14'd1234, 14'd5678, 14'd9012};
    drain();

    // everything at maximum, stored stroke and gap
    load_settings('{10'd1023, 10'd1023, 10'd255, 10'd4, 10'd63, 10'd1, 10'd255, 10'd1});
    number_q = '{14'd8888, 14'd7};
    drain();

    // everything at minimum: zero width, stored stroke of zero, negative starts
    load_settings('{10'd0, 10'd0, 10'd0, 10'd1, 10'd0, 10'd1, 10'd0, 10'd1});
    number_q = '{14'd9999, 14'd5, 14'd10};
    drain();

    // no digit positions
    load_settings('{10'd8, 10'd8, 10'd12, 10'd0, 10'd2, 10'd0, 10'd6, 10'd0});
    number_q = '{14'd1234, 14'd0};
    drain();

    // oversized digit count, junk in the upper data bits, derived stroke/gap
    load_settings('{10'd1023, 10'd1023, 10'h3FF, 10'h3FF, 10'h3C0, 10'h3FE, 10'h3FF, 10'h3FE});
    number_q = '{14'd4321, 14'd1000};
    drain();

    // three digits drop the thousands, derived stroke of zero raised
    load_settings('{10'd100, 10'd50, 10'd5, 10'd3, 10'd9, 10'd0, 10'd3, 10'd0});
    number_q = '{14'd9876, 14'd47};
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int i = 0; i < 8; i++) vals[i] = $urandom_range(0, 2**ssrr_pkg::CFG_W - 1);
      vals[ssrr_pkg::CFG_DIGIT_CNT][2:0] = $urandom_range(1, 7);
      if (ph == 2) vals[ssrr_pkg::CFG_SEG_WIDTH][7:0] = $urandom_range(0, 7);
      no_idle = (ph == 1 || ph == 4);
      load_settings(vals);
      good = 0;
      while (good < RAND_PER_SET) begin
        case ($urandom_range(0, 9))
          0, 1:    num = $urandom_range(0, 99);
          2:       num = $urandom_range(ssrr_pkg::NUM_LIMIT, 2**ssrr_pkg::NUM_W - 1);
          default: num = $urandom_range(0, ssrr_pkg::NUM_LIMIT - 1);
        endcase
        if (num < ssrr_pkg::NUM_LIMIT) good++;
        number_q.push_back(num);
      end
      drain();
    end
    no_idle = 1'b0;

    $display("covered %0d numbers (%0d out of range) over %0d register settings",
             n_numbers, n_rejected, n_settings);
    $display("checked %0d rects, %0d mismatched", n_rects, n_bad);
    if (n_bad == 0) begin
      $display("** seven_segment_rect_renderer: PASSED **");
    end else begin
      $display("** seven_segment_rect_renderer: FAILED **");
    end
    $finish;
  end

endmodule
